// ===== hw/rtl/mmh_pkg.sv =====
`timescale 1ns / 1ps

package mmh_pkg;

    // Sizing of the stores
    localparam int SAMPLE_BITS  = 16;
    localparam int CHANNEL_BITS = 8;
    localparam int COUNT_BITS   = 32;

    localparam int GREY_DEPTH = 1 << SAMPLE_BITS;
    localparam int CHAN_DEPTH = 1 << CHANNEL_BITS;

    // Three channel counts summed need two extra bits
    localparam int SUM_BITS = COUNT_BITS + 2;
    localparam int AVG_DIV  = 3;

    // Divide by three: shift-add estimate of n/3 from below, then a small fix-up
    // on the residue; 11/32 gives floor(r/3) exactly for residues under 32
    localparam int RESID_BITS   = 6;
    localparam int RECIP_MUL    = 11;
    localparam int RECIP_SHIFT  = 5;
    localparam int DIV_CNT_BITS = 3;

    localparam logic [DIV_CNT_BITS-1:0] DSTEP_SEED  = 3'd4;
    localparam logic [DIV_CNT_BITS-1:0] DSTEP_FOLD1 = 3'd3;
    localparam logic [DIV_CNT_BITS-1:0] DSTEP_FOLD2 = 3'd2;
    localparam logic [DIV_CNT_BITS-1:0] DSTEP_RESID = 3'd1;
    localparam logic [DIV_CNT_BITS-1:0] DSTEP_FIX   = 3'd0;

    // Port field widths
    localparam int MODE_W   = 2;
    localparam int FUNC_W   = 2;
    localparam int SAMPLE_W = 16;
    localparam int CHAN_W   = 8;
    localparam int BIN_W    = 16;
    localparam int COUNT_W  = 32;
    localparam int REM_W    = 2;

    localparam logic [MODE_W-1:0] MODE_GREY16     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GREY8      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COLOUR     = 2'd2;
    localparam int                MODE_COLOUR_BIT = 1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_DIV,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic capture;
        logic sweep;
        logic bump;
        logic load;
        logic div_step;
        logic push;
    } mmh_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic is_read;
        logic colour;
        logic div_last;
        logic out_free;
    } mmh_sts_t;

endpackage

// ===== hw/rtl/mmh_in_if.sv =====
`timescale 1ns / 1ps

interface mmh_in_if import mmh_pkg::*;;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic [BIN_W-1:0]    bin;

    modport source (output valid, func, sample, red, green, blue, bin, input ready);
    modport sink   (input valid, func, sample, red, green, blue, bin, output ready);
endinterface

// ===== hw/rtl/mmh_out_if.sv =====
`timescale 1ns / 1ps

interface mmh_out_if import mmh_pkg::*;;
    logic               valid;
    logic               ready;
    logic [BIN_W-1:0]   bin_index;
    logic [COUNT_W-1:0] count;
    logic [REM_W-1:0]   remainder;

    modport source (output valid, bin_index, count, remainder, input ready);
    modport sink   (input valid, bin_index, count, remainder, output ready);
endinterface

// ===== hw/rtl/mmh_cfg_if.sv =====
`timescale 1ns / 1ps

interface mmh_cfg_if import mmh_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;

    modport source (output valid, mode, input ready);
    modport sink   (input valid, mode, output ready);
endinterface

// ===== hw/rtl/mmh_ram.sv =====
`timescale 1ns / 1ps

module mmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/mmh_ctrl.sv =====
`timescale 1ns / 1ps

module mmh_ctrl import mmh_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [FUNC_W-1:0] req_func,
    output logic              req_ready,
    input  mmh_sts_t          sts,
    output mmh_cmd_t          cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_func)
                        FUNC_ADD, FUNC_READ: state_next = ST_LOOKUP;
                        FUNC_CLEAR:          state_next = ST_SWEEP;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!sts.is_read)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.colour)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
            end
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            ST_LOOKUP:
            begin
                // read addresses settle from the captured item
            end
            ST_UPDATE:
            begin
                cmd.bump = !sts.is_read;
                cmd.load = sts.is_read;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_PUSH:
            begin
                cmd.push = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/mmh_datapath.sv =====
`timescale 1ns / 1ps

module mmh_datapath import mmh_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  mmh_cmd_t            cmd,
    output mmh_sts_t            sts,
    input  logic                cfg_we,
    input  logic [MODE_W-1:0]   cfg_mode,
    input  logic [FUNC_W-1:0]   func,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [CHAN_W-1:0]   red,
    input  logic [CHAN_W-1:0]   green,
    input  logic [CHAN_W-1:0]   blue,
    input  logic [BIN_W-1:0]    bin,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    output logic [BIN_W-1:0]    bin_index,
    output logic [COUNT_W-1:0]  count,
    output logic [REM_W-1:0]    remainder
);

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    // Control registers
    logic [MODE_W-1:0]      mode_reg,      mode_next;
    logic [SAMPLE_BITS-1:0] clr_cnt_reg,   clr_cnt_next;
    logic                   out_valid_reg, out_valid_next;

    // Item and result registers
    logic                    is_read_reg,   is_read_next;
    logic [SAMPLE_BITS-1:0]  sample_reg,    sample_next;
    logic [CHANNEL_BITS-1:0] red_reg,       red_next;
    logic [CHANNEL_BITS-1:0] green_reg,     green_next;
    logic [CHANNEL_BITS-1:0] blue_reg,      blue_next;
    logic [BIN_W-1:0]        bin_reg,       bin_next;
    logic [SUM_BITS-1:0]     sum_reg,       sum_next;
    logic [SUM_BITS-1:0]     quo_reg,       quo_next;
    logic [RESID_BITS-1:0]   resid_reg,     resid_next;
    logic [REM_W-1:0]        rem_reg,       rem_next;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg,   div_cnt_next;
    logic [BIN_W-1:0]        out_bin_reg,   out_bin_next;
    logic [COUNT_W-1:0]      out_count_reg, out_count_next;
    logic [REM_W-1:0]        out_rem_reg,   out_rem_next;

    logic                    colour;
    logic                    in_range;
    logic [SAMPLE_BITS-1:0]  grey_add_addr;
    logic [SAMPLE_BITS-1:0]  grey_addr;
    logic [SAMPLE_BITS-1:0]  grey_waddr;
    logic [COUNT_BITS-1:0]   grey_wdata, grey_rdata;
    logic                    grey_we;
    logic [CHANNEL_BITS-1:0] chan_bin;
    logic [CHANNEL_BITS-1:0] r_addr, g_addr, b_addr;
    logic [CHANNEL_BITS-1:0] r_waddr, g_waddr, b_waddr;
    logic [COUNT_BITS-1:0]   r_wdata, g_wdata, b_wdata;
    logic [COUNT_BITS-1:0]   r_rdata, g_rdata, b_rdata;
    logic                    chan_we;
    logic [SUM_BITS-1:0]     chan_sum;
    logic [SUM_BITS-1:0]     seed_q;
    logic [SUM_BITS-1:0]     fold_a, fold_b, fold_c, fold_d;
    logic [SUM_BITS-1:0]     triple_q;
    logic [SUM_BITS-1:0]     resid_full;
    logic [RESID_BITS+3:0]   fix_prod;
    logic [RESID_BITS-1:0]   fix_q;

    assign colour   = mode_reg[MODE_COLOUR_BIT];
    assign in_range = (bin_reg[BIN_W-1:CHANNEL_BITS] == '0);
    assign chan_bin = bin_reg[CHANNEL_BITS-1:0];

    // 8-bit grey folds the sample onto the low bins
    assign grey_add_addr = (mode_reg == MODE_GREY16) ? sample_reg
                         : SAMPLE_BITS'(sample_reg[CHANNEL_BITS-1:0]);
    assign grey_addr = is_read_reg ? bin_reg[SAMPLE_BITS-1:0] : grey_add_addr;
    assign r_addr    = is_read_reg ? chan_bin : red_reg;
    assign g_addr    = is_read_reg ? chan_bin : green_reg;
    assign b_addr    = is_read_reg ? chan_bin : blue_reg;

    assign grey_we    = cmd.sweep || (cmd.bump && !colour);
    assign grey_waddr = cmd.sweep ? clr_cnt_reg : grey_addr;
    assign grey_wdata = cmd.sweep ? '0 : sat_inc(grey_rdata);

    assign chan_we = cmd.sweep || (cmd.bump && colour);
    assign r_waddr = cmd.sweep ? clr_cnt_reg[CHANNEL_BITS-1:0] : r_addr;
    assign g_waddr = cmd.sweep ? clr_cnt_reg[CHANNEL_BITS-1:0] : g_addr;
    assign b_waddr = cmd.sweep ? clr_cnt_reg[CHANNEL_BITS-1:0] : b_addr;
    assign r_wdata = cmd.sweep ? '0 : sat_inc(r_rdata);
    assign g_wdata = cmd.sweep ? '0 : sat_inc(g_rdata);
    assign b_wdata = cmd.sweep ? '0 : sat_inc(b_rdata);

    mmh_ram #(.WIDTH(COUNT_BITS), .DEPTH(GREY_DEPTH)) u_grey_ram (
        .clk   (clk),
        .we    (grey_we),
        .waddr (grey_waddr),
        .wdata (grey_wdata),
        .raddr (grey_addr),
        .rdata (grey_rdata)
    );

    mmh_ram #(.WIDTH(COUNT_BITS), .DEPTH(CHAN_DEPTH)) u_red_ram (
        .clk   (clk),
        .we    (chan_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_addr),
        .rdata (r_rdata)
    );

    mmh_ram #(.WIDTH(COUNT_BITS), .DEPTH(CHAN_DEPTH)) u_green_ram (
        .clk   (clk),
        .we    (chan_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_addr),
        .rdata (g_rdata)
    );

    mmh_ram #(.WIDTH(COUNT_BITS), .DEPTH(CHAN_DEPTH)) u_blue_ram (
        .clk   (clk),
        .we    (chan_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_addr),
        .rdata (b_rdata)
    );

    assign chan_sum = SUM_BITS'(r_rdata) + SUM_BITS'(g_rdata) + SUM_BITS'(b_rdata);

    // n/3 from below: 5/16 * (1 + 1/16)(1 + 1/256)(1 + 2^-16)(1 + 2^-32) ~ 1/3,
    // two adds a cycle; the residue n - 3q stays well under 32
    assign seed_q     = (sum_reg >> 2) + (sum_reg >> 4);
    assign fold_a     = quo_reg + (quo_reg >> 4);
    assign fold_b     = fold_a + (fold_a >> 8);
    assign fold_c     = quo_reg + (quo_reg >> 16);
    assign fold_d     = fold_c + (fold_c >> 32);
    assign triple_q   = quo_reg + {quo_reg[SUM_BITS-2:0], 1'b0};
    assign resid_full = sum_reg - triple_q;
    assign fix_prod   = (RESID_BITS + 4)'(resid_reg) * (RESID_BITS + 4)'(RECIP_MUL);
    assign fix_q      = RESID_BITS'(fix_prod >> RECIP_SHIFT);

    always_comb
    begin
        mode_next      = cfg_we ? cfg_mode : mode_reg;
        clr_cnt_next   = cmd.sweep ? clr_cnt_reg + SAMPLE_BITS'(1) : clr_cnt_reg;
        out_valid_next = out_valid_reg;
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        is_read_next   = is_read_reg;
        sample_next    = sample_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        bin_next       = bin_reg;
        sum_next       = sum_reg;
        quo_next       = quo_reg;
        resid_next     = resid_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        out_bin_next   = out_bin_reg;
        out_count_next = out_count_reg;
        out_rem_next   = out_rem_reg;
        if (cmd.capture)
        begin
            is_read_next = (func == FUNC_READ);
            sample_next  = sample[SAMPLE_BITS-1:0];
            red_next     = red[CHANNEL_BITS-1:0];
            green_next   = green[CHANNEL_BITS-1:0];
            blue_next    = blue[CHANNEL_BITS-1:0];
            bin_next     = bin;
        end
        if (cmd.load)
        begin
            if (colour)
            begin
                sum_next = in_range ? chan_sum : '0;
            end
            else
            begin
                quo_next = SUM_BITS'(grey_rdata);
            end
            rem_next     = '0;
            div_cnt_next = DSTEP_SEED;
        end
        if (cmd.div_step)
        begin
            unique case (div_cnt_reg)
                DSTEP_SEED:  quo_next   = seed_q;
                DSTEP_FOLD1: quo_next   = fold_b;
                DSTEP_FOLD2: quo_next   = fold_d;
                DSTEP_RESID: resid_next = RESID_BITS'(resid_full);
                DSTEP_FIX:
                begin
                    quo_next = quo_reg + SUM_BITS'(fix_q);
                    rem_next = REM_W'(resid_reg - fix_q - {fix_q[RESID_BITS-2:0], 1'b0});
                end
                default:     quo_next   = quo_reg;
            endcase
            div_cnt_next = div_cnt_reg - DIV_CNT_BITS'(1);
        end
        if (cmd.push)
        begin
            out_bin_next   = bin_reg;
            out_count_next = COUNT_W'(quo_reg);
            out_rem_next   = rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_GREY16;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_read_reg   <= is_read_next;
        sample_reg    <= sample_next;
        red_reg       <= red_next;
        green_reg     <= green_next;
        blue_reg      <= blue_next;
        bin_reg       <= bin_next;
        sum_reg       <= sum_next;
        quo_reg       <= quo_next;
        resid_reg     <= resid_next;
        rem_reg       <= rem_next;
        div_cnt_reg   <= div_cnt_next;
        out_bin_reg   <= out_bin_next;
        out_count_reg <= out_count_next;
        out_rem_reg   <= out_rem_next;
    end

    assign sts.sweep_last = &clr_cnt_reg;
    assign sts.is_read    = is_read_reg;
    assign sts.colour     = colour;
    assign sts.div_last   = (div_cnt_reg == DSTEP_FIX);
    assign sts.out_free   = !out_valid_reg || rsp_ready;

    assign rsp_valid = out_valid_reg;
    assign bin_index = out_bin_reg;
    assign count     = out_count_reg;
    assign remainder = out_rem_reg;

endmodule

// ===== hw/rtl/multi_mode_image_histogram.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Payload                              Accepted when
// cfg      in   mode[1:0]                            cfg.valid & cfg.ready (ready always high)
// req      in   func, sample, red, green, blue, bin  req.valid & req.ready
// rsp      out  bin_index, count, remainder          rsp.valid & rsp.ready
//
// One item at a time. Add: capture, store lookup, read-modify-write. Grey read:
// capture, lookup, load, push; colour read: the same with a shift-add divide by three
// (seed, first fold, second fold, residue, small fix-up) before the push. Clear sweeps
// one grey bin a cycle. After reset the same clearing sweep runs before the first item
// is taken; mode writes are taken throughout. A stalled rsp holds one result in its
// output register; a read item then waits in its last state until that register frees.

module multi_mode_image_histogram import mmh_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    mmh_cfg_if.sink  cfg,
    mmh_in_if.sink   req,
    mmh_out_if.source rsp
);

    mmh_cmd_t cmd;
    mmh_sts_t sts;

    assign cfg.ready = 1'b1;

    mmh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (req.func),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mmh_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg.valid),
        .cfg_mode  (cfg.mode),
        .func      (req.func),
        .sample    (req.sample),
        .red       (req.red),
        .green     (req.green),
        .blue      (req.blue),
        .bin       (req.bin),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .bin_index (rsp.bin_index),
        .count     (rsp.count),
        .remainder (rsp.remainder)
    );

    // a result is never loaded while the block is open for a new item
    a_push_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && cmd.push))
        else $error("result loaded while accepting items");

    // a clear item closes the input for its sweep
    a_clear_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.func == FUNC_CLEAR) |=> !req.ready)
        else $error("input open after clear item");

    // divide-by-three remainder stays below three
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.remainder != 2'd3))
        else $error("remainder out of range");

endmodule
